// ===== sv/hpt_pkg.sv =====
// Shared types, widths, codes and the sine table for the heading/position tracker.
package hpt_pkg;

    localparam int COORD_FRAC_BITS = 8;
    localparam int SINE_BITS       = 16;

    localparam int POS_W      = 24;
    localparam int HEAD_W     = 9;
    localparam int TRAVEL_W   = 24;
    localparam int TURN_W     = 10;
    localparam int FIELD_W    = 15;
    localparam int MARGIN_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int SINE_W      = SINE_BITS + 1;   // sin(90) is exactly 2^SINE_BITS
    localparam int QUARTER     = 90;
    localparam int FULL_TURN   = 360;
    localparam int FIELD_RESET = 100;

    typedef enum logic {
        OP_MOVE   = 1'b0,
        OP_ROTATE = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE         = 2'd0,
        STAT_MOVE_REFUSED = 2'd1,
        STAT_TURN_RANGE   = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIELD_WIDTH   = 3'd0,
        REG_FIELD_LENGTH  = 3'd1,
        REG_MARGIN_X      = 3'd2,
        REG_MARGIN_Y      = 3'd3,
        REG_START_X       = 3'd4,
        REG_START_Y       = 3'd5,
        REG_START_HEADING = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic                    refused;
    } t_move_res;

    typedef struct packed {
        logic [HEAD_W-1:0] heading;
        logic              refused;
    } t_turn_res;

    // Quarter-wave table, built at elaboration by a 1-degree rotation in Q62.
    typedef logic [SINE_W-1:0] t_sine_tab [0:QUARTER];

    localparam logic [63:0] Q62_ONE  = 64'h4000_0000_0000_0000;
    localparam logic [63:0] Q62_SIN1 = 64'd80485018754665600;
    localparam logic [63:0] Q62_COS1 = 64'd4610983636309388000;

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] ns;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] rnd;
        s = 64'd0;
        c = Q62_ONE;
        for (int d = 0; d <= QUARTER; d++) begin
            rnd    = (s + (64'd1 << (61 - SINE_BITS))) >> (62 - SINE_BITS);
            tab[d] = rnd[SINE_W-1:0];
            ns     = mul_q62(s, Q62_COS1) + mul_q62(c, Q62_SIN1);
            a      = mul_q62(c, Q62_COS1);
            b      = mul_q62(s, Q62_SIN1);
            c      = (a > b) ? a - b : 64'd0;
            s      = ns;
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

// ===== sv/hpt_if.sv =====
// Command and result channel interfaces (valid/ready with payload).
interface hpt_cmd_if;
    import hpt_pkg::*;

    logic                       valid;
    logic                       ready;
    t_opcode                    opcode;
    logic signed [TRAVEL_W-1:0] travel;
    logic signed [TURN_W-1:0]   turn;

    modport source (output valid, output opcode, output travel, output turn, input ready);
    modport sink   (input valid, input opcode, input travel, input turn, output ready);
endinterface

interface hpt_res_if;
    import hpt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [HEAD_W-1:0]       heading;
    t_status                 status;

    modport source (output valid, output pos_x, output pos_y, output heading, output status,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading, input status,
                    output ready);
endinterface

// ===== sv/hpt_move_unit.sv =====
// Move datapath: sine/cosine lookup, scaled products, field bound check.
module hpt_move_unit (
    input  logic signed [hpt_pkg::POS_W-1:0]    i_cur_x,
    input  logic signed [hpt_pkg::POS_W-1:0]    i_cur_y,
    input  logic [hpt_pkg::HEAD_W-1:0]          i_heading,
    input  logic signed [hpt_pkg::TRAVEL_W-1:0] i_travel,
    input  logic [hpt_pkg::FIELD_W-1:0]         i_field_width,
    input  logic [hpt_pkg::FIELD_W-1:0]         i_field_length,
    input  logic [hpt_pkg::MARGIN_W-1:0]        i_margin_x,
    input  logic [hpt_pkg::MARGIN_W-1:0]        i_margin_y,
    output hpt_pkg::t_move_res                  o_res
);
    import hpt_pkg::*;

    localparam int PROD_W = TRAVEL_W + SINE_W + 1;
    localparam int TERM_W = TRAVEL_W + 3;
    localparam int CALC_W = POS_W + 4;
    localparam int BND_W  = FIELD_W + COORD_FRAC_BITS + 2;
    localparam int CMP_W  = (CALC_W > BND_W) ? CALC_W : BND_W;
    localparam int IDX_W  = $clog2(QUARTER + 1);

    localparam logic signed [CMP_W-1:0] POS_MAX_C = CMP_W'(2 ** (POS_W - 1) - 1);
    localparam logic signed [CMP_W-1:0] POS_MIN_C = CMP_W'(-(2 ** (POS_W - 1)));

    // distance * sine, rounded to nearest with ties away from zero
    function automatic logic signed [TERM_W-1:0] scale_round(
        input logic signed [TRAVEL_W-1:0] trav,
        input logic signed [SINE_W:0]     sn
    );
        logic signed [PROD_W-1:0] p;
        logic [PROD_W-1:0]        mag;
        logic [PROD_W-1:0]        rnd;
        logic signed [TERM_W-1:0] term;
        p    = PROD_W'(trav) * PROD_W'(sn);
        mag  = p[PROD_W-1] ? unsigned'(-p) : unsigned'(p);
        rnd  = (mag + (PROD_W'(1) << (SINE_BITS - 1))) >> SINE_BITS;
        term = signed'({1'b0, rnd[TERM_W-2:0]});
        return p[PROD_W-1] ? -term : term;
    endfunction

    logic [IDX_W-1:0]         rem;
    logic                     swap;
    logic                     sn_neg;
    logic                     cs_neg;
    logic [SINE_W-1:0]        tab_a;
    logic [SINE_W-1:0]        tab_b;
    logic signed [SINE_W:0]   sn;
    logic signed [SINE_W:0]   cs;
    logic signed [TERM_W-1:0] dx;
    logic signed [TERM_W-1:0] dy;
    logic signed [CMP_W-1:0]  nx;
    logic signed [CMP_W-1:0]  ny;
    logic signed [CMP_W-1:0]  hi_x;
    logic signed [CMP_W-1:0]  hi_y;
    logic signed [CMP_W-1:0]  lo_x;
    logic signed [CMP_W-1:0]  lo_y;

    // quadrant folding onto the 0..90 table
    always_comb begin
        priority if (i_heading >= HEAD_W'(3 * QUARTER)) begin
            rem = IDX_W'(i_heading - HEAD_W'(3 * QUARTER));
            swap = 1'b1; sn_neg = 1'b1; cs_neg = 1'b0;
        end else if (i_heading >= HEAD_W'(2 * QUARTER)) begin
            rem = IDX_W'(i_heading - HEAD_W'(2 * QUARTER));
            swap = 1'b0; sn_neg = 1'b1; cs_neg = 1'b1;
        end else if (i_heading >= HEAD_W'(QUARTER)) begin
            rem = IDX_W'(i_heading - HEAD_W'(QUARTER));
            swap = 1'b1; sn_neg = 1'b0; cs_neg = 1'b1;
        end else begin
            rem = IDX_W'(i_heading);
            swap = 1'b0; sn_neg = 1'b0; cs_neg = 1'b0;
        end
    end

    assign tab_a = SINE_TAB[rem];
    assign tab_b = SINE_TAB[IDX_W'(QUARTER) - rem];

    always_comb begin
        sn = signed'({1'b0, (swap ? tab_b : tab_a)});
        cs = signed'({1'b0, (swap ? tab_a : tab_b)});
        if (sn_neg) begin
            sn = -sn;
        end
        if (cs_neg) begin
            cs = -cs;
        end
    end

    assign dx = scale_round(i_travel, sn);
    assign dy = scale_round(i_travel, cs);

    assign nx = CMP_W'(i_cur_x) + CMP_W'(dx);
    assign ny = CMP_W'(i_cur_y) + CMP_W'(dy);

    assign hi_x = signed'(CMP_W'({i_field_width, {COORD_FRAC_BITS{1'b0}}}))
                + signed'(CMP_W'(i_margin_x));
    assign hi_y = signed'(CMP_W'({i_field_length, {COORD_FRAC_BITS{1'b0}}}))
                + signed'(CMP_W'(i_margin_y));
    assign lo_x = -signed'(CMP_W'(i_margin_x));
    assign lo_y = -signed'(CMP_W'(i_margin_y));

    always_comb begin
        o_res.x       = nx[POS_W-1:0];
        o_res.y       = ny[POS_W-1:0];
        o_res.refused = (nx < lo_x) || (nx > hi_x) || (ny < lo_y) || (ny > hi_y)
                     || (nx < POS_MIN_C) || (nx > POS_MAX_C)
                     || (ny < POS_MIN_C) || (ny > POS_MAX_C);
    end

endmodule

// ===== sv/hpt_turn_unit.sv =====
// Rotate datapath: range check and heading update modulo 360.
module hpt_turn_unit (
    input  logic [hpt_pkg::HEAD_W-1:0]        i_heading,
    input  logic signed [hpt_pkg::TURN_W-1:0] i_turn,
    output hpt_pkg::t_turn_res                o_res
);
    import hpt_pkg::*;

    localparam int SUM_W = HEAD_W + 3;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] wrapped;

    // heading + turn + 360 lies in 0..1079, so at most two subtractions
    assign sum = signed'(SUM_W'(i_heading)) + SUM_W'(i_turn) + SUM_W'(FULL_TURN);

    always_comb begin
        priority if (sum >= SUM_W'(2 * FULL_TURN)) begin
            wrapped = sum - SUM_W'(2 * FULL_TURN);
        end else if (sum >= SUM_W'(FULL_TURN)) begin
            wrapped = sum - SUM_W'(FULL_TURN);
        end else begin
            wrapped = sum;
        end
    end

    always_comb begin
        o_res.refused = (i_turn > TURN_W'(FULL_TURN)) || (i_turn < -TURN_W'(FULL_TURN));
        o_res.heading = wrapped[HEAD_W-1:0];
    end

endmodule

// ===== sv/heading_position_tracker.sv =====
// Top level: command register, position/heading state, result register.
//
// Dead-reckoning tracker. Each command item (move or rotate) yields exactly one
// result item carrying the position, heading and status after that command.
// Throughput is one item per cycle while results are taken without back-pressure.
// A command is captured in the command register; from there the move or rotate
// datapath (table lookup, two 24x18 multiplies, rounding, add and bound compare)
// computes the new state, which lands in the state registers and the result
// register at the same edge. Because state is written at that edge, the item
// behind it sees the updated position and heading with no bubble. The result
// register separates the two sides: a new command is accepted while a result
// waits, as long as the command register is empty or moving forward.
// Move: x += travel*sin(heading), y += travel*cos(heading), Q16.8, heading 0
// points along +y. A destination beyond the field widened by the margins, or
// outside the 24-bit signed range, is refused (status 1) and the position is
// kept. Rotate: turns of -360..360 degrees wrap modulo 360; others give
// status 2. Writing start_x/start_y/start_heading also loads the live state
// immediately (a start heading of 360 or more is reduced by 360). Writes to
// unknown register indexes are dropped. Configure only while idle.
module heading_position_tracker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hpt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    hpt_cmd_if.sink                            i_cmd,
    hpt_res_if.source                          o_res
);
    import hpt_pkg::*;

    // configuration
    logic [FIELD_W-1:0]  r_field_width;
    logic [FIELD_W-1:0]  r_field_length;
    logic [MARGIN_W-1:0] r_margin_x;
    logic [MARGIN_W-1:0] r_margin_y;

    // live state
    logic signed [POS_W-1:0] r_cur_x;
    logic signed [POS_W-1:0] r_cur_y;
    logic [HEAD_W-1:0]       r_cur_heading;

    // command register
    logic                       r_cmd_valid;
    t_opcode                    r_opcode;
    logic signed [TRAVEL_W-1:0] r_travel;
    logic signed [TURN_W-1:0]   r_turn;

    // result register
    logic                    r_res_valid;
    logic signed [POS_W-1:0] r_pos_x;
    logic signed [POS_W-1:0] r_pos_y;
    logic [HEAD_W-1:0]       r_heading;
    t_status                 r_status;

    logic              advance;
    logic              cmd_ready;
    logic              fire;
    t_move_res         move_res;
    t_turn_res         turn_res;
    logic [HEAD_W-1:0] cfg_head;

    assign advance   = !r_res_valid || o_res.ready;
    assign cmd_ready = !r_cmd_valid || advance;
    assign fire      = r_cmd_valid && advance;

    assign i_cmd.ready   = cmd_ready;
    assign o_res.valid   = r_res_valid;
    assign o_res.pos_x   = r_pos_x;
    assign o_res.pos_y   = r_pos_y;
    assign o_res.heading = r_heading;
    assign o_res.status  = r_status;

    hpt_move_unit u_move (
        .i_cur_x        (r_cur_x),
        .i_cur_y        (r_cur_y),
        .i_heading      (r_cur_heading),
        .i_travel       (r_travel),
        .i_field_width  (r_field_width),
        .i_field_length (r_field_length),
        .i_margin_x     (r_margin_x),
        .i_margin_y     (r_margin_y),
        .o_res          (move_res)
    );

    hpt_turn_unit u_turn (
        .i_heading (r_cur_heading),
        .i_turn    (r_turn),
        .o_res     (turn_res)
    );

    // start heading reduced once when loaded
    assign cfg_head = (i_cfg_data[HEAD_W-1:0] >= HEAD_W'(FULL_TURN))
                    ? i_cfg_data[HEAD_W-1:0] - HEAD_W'(FULL_TURN)
                    : i_cfg_data[HEAD_W-1:0];

    // command capture (payload needs no reset)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (cmd_ready) begin
            r_cmd_valid <= i_cmd.valid;
        end
        if (cmd_ready && i_cmd.valid) begin
            r_opcode <= i_cmd.opcode;
            r_travel <= i_cmd.travel;
            r_turn   <= i_cmd.turn;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (advance) begin
            r_res_valid <= r_cmd_valid;
        end
        if (fire) begin
            unique case (r_opcode)
                OP_MOVE: begin
                    r_heading <= r_cur_heading;
                    if (move_res.refused) begin
                        r_pos_x  <= r_cur_x;
                        r_pos_y  <= r_cur_y;
                        r_status <= STAT_MOVE_REFUSED;
                    end else begin
                        r_pos_x  <= move_res.x;
                        r_pos_y  <= move_res.y;
                        r_status <= STAT_DONE;
                    end
                end
                OP_ROTATE: begin
                    r_pos_x <= r_cur_x;
                    r_pos_y <= r_cur_y;
                    if (turn_res.refused) begin
                        r_heading <= r_cur_heading;
                        r_status  <= STAT_TURN_RANGE;
                    end else begin
                        r_heading <= turn_res.heading;
                        r_status  <= STAT_DONE;
                    end
                end
                default: begin
                    r_status <= STAT_DONE;
                end
            endcase
        end
    end

    // configuration and live state; writes must come only while idle, which the block itself does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_width  <= FIELD_W'(FIELD_RESET);
            r_field_length <= FIELD_W'(FIELD_RESET);
            r_margin_x     <= '0;
            r_margin_y     <= '0;
            r_cur_x        <= '0;
            r_cur_y        <= '0;
            r_cur_heading  <= '0;
        end else begin
            if (fire) begin
                unique case (r_opcode)
                    OP_MOVE: begin
                        if (!move_res.refused) begin
                            r_cur_x <= move_res.x;
                            r_cur_y <= move_res.y;
                        end
                    end
                    OP_ROTATE: begin
                        if (!turn_res.refused) begin
                            r_cur_heading <= turn_res.heading;
                        end
                    end
                    default: begin
                        r_cur_heading <= r_cur_heading;
                    end
                endcase
            end
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_FIELD_WIDTH:   r_field_width  <= i_cfg_data[FIELD_W-1:0];
                    REG_FIELD_LENGTH:  r_field_length <= i_cfg_data[FIELD_W-1:0];
                    REG_MARGIN_X:      r_margin_x     <= i_cfg_data[MARGIN_W-1:0];
                    REG_MARGIN_Y:      r_margin_y     <= i_cfg_data[MARGIN_W-1:0];
                    REG_START_X:       r_cur_x        <= signed'(i_cfg_data[POS_W-1:0]);
                    REG_START_Y:       r_cur_y        <= signed'(i_cfg_data[POS_W-1:0]);
                    REG_START_HEADING: r_cur_heading  <= cfg_head;
                    default: begin
                        r_margin_x <= r_margin_x;
                    end
                endcase
            end
        end
    end

endmodule
